// ----- hdl/vrp_pkg.sv -----
// Shared types, widths and helpers for the vertex rotate and project pipeline.
package vrp_pkg;

  localparam int CW        = 16;          // Q7.8 coordinate width
  localparam int TW        = 16;          // Q1.14 trig width
  localparam int VW        = 15;          // view distance width
  localparam int RW        = 24;          // internal rotated value width
  localparam int PW        = RW + TW;     // product width
  localparam int QW        = 18;          // quotient bits kept before clamping
  localparam int MW        = 40;          // dividend / remainder width
  localparam int DENW      = 20;          // divisor width
  localparam int FRAC_TRIG = 14;
  localparam int ROUND_HALF = 8192;
  localparam int ROT_LAT   = 2;
  localparam int PROJ_LAT  = QW + 3;
  localparam int PIPE_LAT  = 3 * ROT_LAT + PROJ_LAT;
  localparam int CENTRE_X_Q = 63 * 256;
  localparam int CENTRE_Y_Q = 31 * 256;
  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN   = -32768;

  localparam logic [TW-1:0] TRIG_ONE   = 16'd16384;
  localparam logic [TW-1:0] TRIG_ZERO  = 16'd0;
  localparam logic [VW-1:0] VIEW_RESET = 15'd10240;

  typedef enum logic [2:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5,
    REG_VIEW  = 3'd6
  } reg_idx_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [RW-1:0] rot_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t vertex_z;
    logic   last_in;
  } in_word_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
    coord_t screen_x;
    coord_t screen_y;
    logic   depth_fault;
    logic   last_out;
  } out_word_t;

  typedef struct packed {
    coord_t rotated_x;
    coord_t rotated_y;
    coord_t rotated_z;
    coord_t screen_x;
    coord_t screen_y;
    logic   depth_fault;
  } proj_res_t;

  function automatic coord_t sat_q78(input rot_t v);
    coord_t r;
    if (v > RW'(SAT_MAX)) r = CW'(SAT_MAX);
    else if (v < RW'(SAT_MIN)) r = CW'(SAT_MIN);
    else r = v[CW-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/vrp_rot.sv -----
// One plane rotation: p = a*c - b*s, q = a*s + b*c, rounded to Q15.8 over two stages.
module vrp_rot import vrp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  rot_t  a,
  input  rot_t  b,
  input  trig_t c,
  input  trig_t s,
  output rot_t  p,
  output rot_t  q
);

  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [PW:0]   sum_p, sum_q, sh_p, sh_q;
  rot_t p_r, q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r <= a * c;
      bs_r <= b * s;
      as_r <= a * s;
      bc_r <= b * c;
    end
  end

  // round half up: add half an LSB then floor shift
  always_comb begin
    sum_p = (PW+1)'(ac_r) - (PW+1)'(bs_r) + (PW+1)'(ROUND_HALF);
    sum_q = (PW+1)'(as_r) + (PW+1)'(bc_r) + (PW+1)'(ROUND_HALF);
    sh_p  = sum_p >>> FRAC_TRIG;
    sh_q  = sum_q >>> FRAC_TRIG;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sh_p[RW-1:0];
      q_r <= sh_q[RW-1:0];
    end
  end

  assign p = p_r;
  assign q = q_r;

endmodule

// ----- hdl/vrp_proj.sv -----
// Perspective projection: scale, bit-per-stage rounded division, centre and saturate.
module vrp_proj import vrp_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  rot_t           x3,
  input  rot_t           y3,
  input  rot_t           z2,
  input  logic [VW-1:0]  view_dist,
  output proj_res_t      res
);

  typedef struct packed {
    logic [DENW-1:0] den;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            fault;
    coord_t          rx;
    coord_t          ry;
    coord_t          rz;
  } side_t;

  logic signed [TW-1:0] dsx;
  logic signed [RW:0]   den_s;

  // first stage: scale by d, form the denominator
  logic signed [PW-1:0] nx_r, ny_r;
  logic [DENW-1:0]      den_r;
  logic                 fault_r;
  coord_t               rx_r, ry_r, rz_r;

  always_comb begin
    dsx   = {1'b0, view_dist};
    den_s = (RW+1)'(z2) + (RW+1)'(dsx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r    <= x3 * dsx;
      ny_r    <= y3 * dsx;
      den_r   <= den_s[DENW-1:0];
      fault_r <= den_s[RW] || (den_s == '0);
      rx_r    <= sat_q78(x3);
      ry_r    <= sat_q78(y3);
      rz_r    <= sat_q78(z2);
    end
  end

  // second stage: magnitude plus half the divisor, overflow check
  logic [MW-1:0]   abs_x, abs_y, mag_x, mag_y, lim;
  logic [DENW-1:0] dv;
  logic [MW-1:0]   mx_r, my_r;
  side_t           s2_r;

  always_comb begin
    dv    = fault_r ? DENW'(1) : den_r;
    abs_x = nx_r[PW-1] ? MW'(-nx_r) : MW'(nx_r);
    abs_y = ny_r[PW-1] ? MW'(-ny_r) : MW'(ny_r);
    mag_x = abs_x + MW'(dv >> 1);
    mag_y = abs_y + MW'(dv >> 1);
    lim   = MW'(dv) << QW;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r        <= mag_x;
      my_r        <= mag_y;
      s2_r.den    <= dv;
      s2_r.neg_x  <= nx_r[PW-1];
      s2_r.neg_y  <= ny_r[PW-1];
      s2_r.ovf_x  <= (mag_x >= lim);
      s2_r.ovf_y  <= (mag_y >= lim);
      s2_r.fault  <= fault_r;
      s2_r.rx     <= rx_r;
      s2_r.ry     <= ry_r;
      s2_r.rz     <= rz_r;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  logic [MW-1:0] rem_x_r [QW];
  logic [MW-1:0] rem_y_r [QW];
  logic [QW-1:0] qx_r    [QW];
  logic [QW-1:0] qy_r    [QW];
  side_t         sd_r    [QW];

  logic [MW-1:0] rx_in   [QW];
  logic [MW-1:0] ry_in   [QW];
  logic [QW-1:0] qx_in   [QW];
  logic [QW-1:0] qy_in   [QW];
  side_t         sd_in   [QW];
  logic [MW-1:0] dsh     [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rx_in[i] = mx_r;
        ry_in[i] = my_r;
        qx_in[i] = '0;
        qy_in[i] = '0;
        sd_in[i] = s2_r;
      end else begin
        rx_in[i] = rem_x_r[i-1];
        ry_in[i] = rem_y_r[i-1];
        qx_in[i] = qx_r[i-1];
        qy_in[i] = qy_r[i-1];
        sd_in[i] = sd_r[i-1];
      end
      dsh[i] = MW'(sd_in[i].den) << (QW - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        sd_r[i] <= sd_in[i];
        if (rx_in[i] >= dsh[i]) begin
          rem_x_r[i] <= rx_in[i] - dsh[i];
          qx_r[i]    <= {qx_in[i][QW-2:0], 1'b1};
        end else begin
          rem_x_r[i] <= rx_in[i];
          qx_r[i]    <= {qx_in[i][QW-2:0], 1'b0};
        end
        if (ry_in[i] >= dsh[i]) begin
          rem_y_r[i] <= ry_in[i] - dsh[i];
          qy_r[i]    <= {qy_in[i][QW-2:0], 1'b1};
        end else begin
          rem_y_r[i] <= ry_in[i];
          qy_r[i]    <= {qy_in[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // last stage: clamp overflow, apply sign, add centre, saturate
  side_t                sl;
  logic [QW-1:0]        qcx, qcy;
  logic signed [QW+1:0] vx, vy;
  proj_res_t            res_r;

  always_comb begin
    sl  = sd_r[QW-1];
    qcx = sl.ovf_x ? '1 : qx_r[QW-1];
    qcy = sl.ovf_y ? '1 : qy_r[QW-1];
    vx  = sl.neg_x ? -$signed({2'b00, qcx}) : $signed({2'b00, qcx});
    vy  = sl.neg_y ? -$signed({2'b00, qcy}) : $signed({2'b00, qcy});
    vx  = vx + (QW+2)'(CENTRE_X_Q);
    vy  = vy + (QW+2)'(CENTRE_Y_Q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.rotated_x   <= sl.rx;
      res_r.rotated_y   <= sl.ry;
      res_r.rotated_z   <= sl.rz;
      res_r.depth_fault <= sl.fault;
      res_r.screen_x    <= sl.fault ? '0 : sat_q78(RW'(vx));
      res_r.screen_y    <= sl.fault ? '0 : sat_q78(RW'(vy));
    end
  end

  assign res = res_r;

endmodule

// ----- hdl/vertex_rotate_project_3d_core.sv -----
// Top level: config registers, X-Y-Z rotation chain, projection and output skid.
//
//  port group | dir | handshake            | payload
//  in_        | in  | in_valid / in_ready  | in_data   (in_word_t)
//  out_       | out | out_valid / out_ready| out_data  (out_word_t)
//  cfg_       | in  | cfg_we               | cfg_idx, cfg_wdata
//
// One word per cycle while the output is not stalled; the path runs through the three rotations
// (multiply, then add and round), the projection (scale, magnitude,
// 18 divider stages, centre and saturate) and the output register.
// Synchronous active-low reset clears the valid bits and loads the register defaults.
// A stalled output fills a skid register; only then does the pipeline hold and in_ready drop.
module vertex_rotate_project_3d_core import vrp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [TW-1:0]    cfg_wdata
);

  trig_t         cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r;
  logic [VW-1:0] view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_x_r <= TRIG_ONE;
      sin_x_r <= TRIG_ZERO;
      cos_y_r <= TRIG_ONE;
      sin_y_r <= TRIG_ZERO;
      cos_z_r <= TRIG_ONE;
      sin_z_r <= TRIG_ZERO;
      view_r  <= VIEW_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_COS_X: cos_x_r <= cfg_wdata;
        REG_SIN_X: sin_x_r <= cfg_wdata;
        REG_COS_Y: cos_y_r <= cfg_wdata;
        REG_SIN_Y: sin_y_r <= cfg_wdata;
        REG_COS_Z: cos_z_r <= cfg_wdata;
        REG_SIN_Z: sin_z_r <= cfg_wdata;
        REG_VIEW:  view_r  <= cfg_wdata[VW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r, out_v_r;
  logic v_r    [PIPE_LAT];
  logic last_r [PIPE_LAT];

  // advance everything unless the skid is holding a word
  assign en       = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < PIPE_LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0] <= in_data.last_in;
      for (int k = 1; k < PIPE_LAT; k++) last_r[k] <= last_r[k-1];
    end
  end

  // side paths that wait beside each rotation
  coord_t xd_r  [ROT_LAT];
  rot_t   y1d_r [ROT_LAT];
  rot_t   z2d_r [ROT_LAT];
  rot_t   y1, z1, x2, z2, x3, y3;

  vrp_rot u_rot_x (
    .clk (clk), .en (en),
    .a (RW'(in_data.vertex_y)), .b (RW'(in_data.vertex_z)),
    .c (cos_x_r), .s (sin_x_r),
    .p (y1), .q (z1)
  );

  vrp_rot u_rot_y (
    .clk (clk), .en (en),
    .a (z1), .b (RW'(xd_r[ROT_LAT-1])),
    .c (cos_y_r), .s (sin_y_r),
    .p (z2), .q (x2)
  );

  vrp_rot u_rot_z (
    .clk (clk), .en (en),
    .a (x2), .b (y1d_r[ROT_LAT-1]),
    .c (cos_z_r), .s (sin_z_r),
    .p (x3), .q (y3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r[0]  <= in_data.vertex_x;
      y1d_r[0] <= y1;
      z2d_r[0] <= z2;
      for (int k = 1; k < ROT_LAT; k++) begin
        xd_r[k]  <= xd_r[k-1];
        y1d_r[k] <= y1d_r[k-1];
        z2d_r[k] <= z2d_r[k-1];
      end
    end
  end

  proj_res_t pres;

  vrp_proj u_proj (
    .clk       (clk),
    .en        (en),
    .x3        (x3),
    .y3        (y3),
    .z2        (z2d_r[ROT_LAT-1]),
    .view_dist (view_r),
    .res       (pres)
  );

  out_word_t arr_w, out_d_r, skid_d_r;

  always_comb begin
    arr_w.rotated_x   = pres.rotated_x;
    arr_w.rotated_y   = pres.rotated_y;
    arr_w.rotated_z   = pres.rotated_z;
    arr_w.screen_x    = pres.screen_x;
    arr_w.screen_y    = pres.screen_y;
    arr_w.depth_fault = pres.depth_fault;
    arr_w.last_out    = last_r[PIPE_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_v_r || out_ready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ready) begin
      out_v_r <= v_r[PIPE_LAT-1];
    end else if (v_r[PIPE_LAT-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (!out_v_r || out_ready) out_d_r <= skid_d_r;
    end else if (!out_v_r || out_ready) begin
      out_d_r <= arr_w;
    end else begin
      skid_d_r <= arr_w;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held with no output word");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready && v_r[PIPE_LAT-1]))
    else $error("skid filled without a stalled output");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.depth_fault) |-> (out_d_r.screen_x == '0 && out_d_r.screen_y == '0))
    else $error("depth fault with non-zero screen point");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (out_v_r && !skid_v_r))
    else $error("skid word not moved to output");

endmodule
